// ----- rtl/icc_pkg.sv -----
// ----------------------------------------------------------------------------
// icc_pkg: shared types and constants of the iteration count colormap
// Widths, register indexes, mode codes, the controller states and the
// result bundle of the quotient unit.
// ----------------------------------------------------------------------------
package icc_pkg;

  localparam int VALUE_W   = 16;
  localparam int COLOR_W   = 8;
  localparam int ENTRY_W   = 8;
  localparam int SIZE_W    = 9;
  localparam int PAL_DEPTH = 256;
  localparam int PAL_AW    = $clog2(PAL_DEPTH);
  localparam int MULB_W    = (PAL_AW > COLOR_W) ? PAL_AW : COLOR_W;
  localparam int NUM_W     = VALUE_W + MULB_W;
  localparam int DIV_CW    = $clog2(NUM_W);
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int RGB_W     = 3 * COLOR_W;

  localparam logic [MULB_W-1:0] GRAY_SCALE = MULB_W'(255);

  localparam logic [1:0] MODE_GRAY = 2'd0;
  localparam logic [1:0] MODE_ABS  = 2'd1;
  localparam logic [1:0] MODE_REL  = 2'd2;

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_MAX  = 2'd1;
  localparam logic [1:0] REG_MIN  = 2'd2;
  localparam logic [1:0] REG_SIZE = 2'd3;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_MAP  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_READ,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
    logic             rem_nz;
  } div_res_t;

endpackage

// ----- rtl/iteration_count_colormap_top.sv -----
// ----------------------------------------------------------------------------
// iteration_count_colormap_top: maps pixel iteration counts to RGB colours
// Loads palette entries and maps values in grayscale, absolute or relative
// palette mode.
// ----------------------------------------------------------------------------
// Usage: items arrive on the in_ valid/ready channel. A load item writes one
// palette entry in the cycle it is accepted and gives no result. A map item
// gives one colour on the out_ valid/ready channel. Registers are written
// through the APB port (mode, max, min, palette size at 0x0, 0x4, 0x8, 0xC).
// The user must write them only while the block is idle; it is not enforced.
// A map item that needs the divider passes a multiply stage, the bit-serial
// divider, a palette read and an output stage on its way to out_valid.
// Trivial cases skip the multiply and the divider: a zero value, min equal to
// max in a palette mode, a grayscale value at or above max, a relative value
// at min or on its far side from max, and max zero in absolute mode.
// One map item is handled at a time; the next item is taken as soon as the
// controller is back in idle.
// A finished colour waits in the output register while the next item is
// taken; if the receiver stalls, the controller waits at the output stage.
// Reset clears the controller and restores the register defaults. Palette
// contents are not reset and an unwritten entry reads as anything.
// ----------------------------------------------------------------------------
module iteration_count_colormap_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_action,
  input  logic [icc_pkg::VALUE_W-1:0]      in_value,
  input  logic [icc_pkg::ENTRY_W-1:0]      in_entry_index,
  input  logic [icc_pkg::COLOR_W-1:0]      in_entry_red,
  input  logic [icc_pkg::COLOR_W-1:0]      in_entry_green,
  input  logic [icc_pkg::COLOR_W-1:0]      in_entry_blue,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [icc_pkg::COLOR_W-1:0]      out_red,
  output logic [icc_pkg::COLOR_W-1:0]      out_green,
  output logic [icc_pkg::COLOR_W-1:0]      out_blue,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [icc_pkg::PADDR_W-1:0]      paddr,
  input  logic [icc_pkg::PDATA_W-1:0]      pwdata,
  output logic [icc_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready
);

  logic [1:0]                      mode_r;
  logic [icc_pkg::VALUE_W-1:0]     max_r;
  logic [icc_pkg::VALUE_W-1:0]     min_r;
  logic [icc_pkg::SIZE_W-1:0]      size_r;
  logic                            cfg_wr;
  logic [1:0]                      reg_sel;

  icc_pkg::state_t                 state_r, state_nxt;
  logic                            div_start;
  logic                            out_load;
  icc_pkg::div_res_t               div_res;

  logic [icc_pkg::PAL_AW-1:0]      last;
  logic                            is_gray;
  logic                            sp;
  logic [icc_pkg::PAL_AW-1:0]      sp_idx;
  logic [icc_pkg::VALUE_W-1:0]     opa;
  logic [icc_pkg::MULB_W-1:0]      opb;
  logic [icc_pkg::VALUE_W-1:0]     den;

  logic                            map_acc;
  logic                            load_acc;

  logic                            is_gray_r;
  logic [icc_pkg::VALUE_W-1:0]     opa_r;
  logic [icc_pkg::MULB_W-1:0]      opb_r;
  logic [icc_pkg::VALUE_W-1:0]     den_r;
  logic [icc_pkg::PAL_AW-1:0]      res_idx_r, res_idx_nxt;
  logic [icc_pkg::COLOR_W-1:0]     gray_r, gray_nxt;
  logic [icc_pkg::NUM_W-1:0]       prod;
  logic [icc_pkg::NUM_W:0]         ceil_q;

  logic [icc_pkg::RGB_W-1:0]       pal_mem [icc_pkg::PAL_DEPTH];
  logic [icc_pkg::RGB_W-1:0]       rd_data_r;
  logic [icc_pkg::RGB_W-1:0]       color;

  logic                            out_valid_r, out_valid_nxt;
  logic [icc_pkg::COLOR_W-1:0]     out_red_r, out_green_r, out_blue_r;

  // Configuration registers.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= icc_pkg::MODE_GRAY;
      max_r  <= icc_pkg::VALUE_W'(255);
      min_r  <= '0;
      size_r <= icc_pkg::SIZE_W'(1);
    end else if (cfg_wr) begin
      case (reg_sel)
        icc_pkg::REG_MODE: mode_r <= pwdata[1:0];
        icc_pkg::REG_MAX:  max_r  <= pwdata[icc_pkg::VALUE_W-1:0];
        icc_pkg::REG_MIN:  min_r  <= pwdata[icc_pkg::VALUE_W-1:0];
        icc_pkg::REG_SIZE: size_r <= pwdata[icc_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      icc_pkg::REG_MODE: prdata = icc_pkg::PDATA_W'(mode_r);
      icc_pkg::REG_MAX:  prdata = icc_pkg::PDATA_W'(max_r);
      icc_pkg::REG_MIN:  prdata = icc_pkg::PDATA_W'(min_r);
      icc_pkg::REG_SIZE: prdata = icc_pkg::PDATA_W'(size_r);
      default:           prdata = '0;
    endcase
  end

  // Last usable palette entry, with the size saturated to the store.
  always_comb begin
    if (size_r == '0) begin
      last = '0;
    end else if (32'(size_r) >= 32'(icc_pkg::PAL_DEPTH)) begin
      last = icc_pkg::PAL_AW'(icc_pkg::PAL_DEPTH - 1);
    end else begin
      last = icc_pkg::PAL_AW'(size_r - icc_pkg::SIZE_W'(1));
    end
  end

  // Operand selection for an incoming map item.
  always_comb begin
    is_gray = !(mode_r == icc_pkg::MODE_ABS || mode_r == icc_pkg::MODE_REL);
    sp      = 1'b1;
    sp_idx  = last;
    opa     = in_value;
    opb     = icc_pkg::MULB_W'(last);
    den     = max_r;
    if (is_gray) begin
      opa    = max_r - in_value;
      opb    = icc_pkg::GRAY_SCALE;
      sp     = (in_value == '0) || (in_value >= max_r);
      sp_idx = '0;
    end else if (in_value == '0 || min_r == max_r) begin
      sp = 1'b1;
    end else if (mode_r == icc_pkg::MODE_ABS) begin
      sp = (max_r == '0);
    end else if (max_r > min_r) begin
      opa = in_value - min_r;
      den = max_r - min_r;
      if (in_value > min_r) begin
        sp = 1'b0;
      end else begin
        sp_idx = '0;
      end
    end else begin
      opa = min_r - in_value;
      den = min_r - max_r;
      if (in_value < min_r) begin
        sp = 1'b0;
      end else begin
        sp_idx = '0;
      end
    end
  end

  assign map_acc  = in_valid && in_ready && (in_action == icc_pkg::ACT_MAP);
  assign load_acc = in_valid && in_ready && (in_action == icc_pkg::ACT_LOAD);

  // Controller: next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      icc_pkg::ST_IDLE: begin
        if (map_acc) begin
          state_nxt = sp ? icc_pkg::ST_READ : icc_pkg::ST_MUL;
        end
      end
      icc_pkg::ST_MUL:  state_nxt = icc_pkg::ST_DIV;
      icc_pkg::ST_DIV: begin
        if (div_res.done) begin
          state_nxt = icc_pkg::ST_READ;
        end
      end
      icc_pkg::ST_READ: state_nxt = icc_pkg::ST_OUT;
      icc_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = icc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = icc_pkg::ST_IDLE;
    endcase
  end

  // Controller: outputs.
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      icc_pkg::ST_IDLE: in_ready  = 1'b1;
      icc_pkg::ST_MUL:  div_start = 1'b1;
      icc_pkg::ST_OUT:  out_load  = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= icc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Multiply, then divide with a ceiling correction.
  assign prod = icc_pkg::NUM_W'(opa_r) * icc_pkg::NUM_W'(opb_r);

  icc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod),
    .den   (den_r),
    .res   (div_res)
  );

  assign ceil_q = {1'b0, div_res.quo} + (icc_pkg::NUM_W + 1)'(div_res.rem_nz);

  always_comb begin
    res_idx_nxt = res_idx_r;
    gray_nxt    = gray_r;
    if (map_acc) begin
      res_idx_nxt = sp_idx;
      gray_nxt    = '0;
    end else if (state_r == icc_pkg::ST_DIV && div_res.done) begin
      gray_nxt = ceil_q[icc_pkg::COLOR_W-1:0];
      if (ceil_q > (icc_pkg::NUM_W + 1)'(last)) begin
        res_idx_nxt = last;
      end else begin
        res_idx_nxt = ceil_q[icc_pkg::PAL_AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (map_acc) begin
      is_gray_r <= is_gray;
      opa_r     <= opa;
      opb_r     <= opb;
      den_r     <= den;
    end
    res_idx_r <= res_idx_nxt;
    gray_r    <= gray_nxt;
  end

  // Palette store.
  always_ff @(posedge clk) begin
    if (load_acc) begin
      pal_mem[in_entry_index[icc_pkg::PAL_AW-1:0]] <=
        {in_entry_red, in_entry_green, in_entry_blue};
    end
    rd_data_r <= pal_mem[res_idx_r];
  end

  // Output register.
  assign color = is_gray_r ? {gray_r, gray_r, gray_r} : rd_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_red_r   <= color[2*icc_pkg::COLOR_W +: icc_pkg::COLOR_W];
      out_green_r <= color[icc_pkg::COLOR_W +: icc_pkg::COLOR_W];
      out_blue_r  <= color[0 +: icc_pkg::COLOR_W];
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

`ifndef SYNTH
  a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == icc_pkg::ST_OUT)
    else $error("Output became valid outside the output stage.");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> state_r == icc_pkg::ST_DIV)
    else $error("Divider finished while the controller was not waiting.");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    load_acc |=> state_r == icc_pkg::ST_IDLE)
    else $error("A load item moved the controller out of idle.");
`endif

endmodule

// ----- rtl/icc_div.sv -----
// ----------------------------------------------------------------------------
// icc_div: restoring divider, one quotient bit per cycle
// Takes a numerator and a non-zero denominator on start and reports the
// quotient and whether the remainder is non-zero once all bits are done.
// ----------------------------------------------------------------------------
module icc_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [icc_pkg::NUM_W-1:0]         num,
  input  logic [icc_pkg::VALUE_W-1:0]       den,
  output icc_pkg::div_res_t                 res
);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [icc_pkg::DIV_CW-1:0]     cnt_r, cnt_nxt;
  logic [icc_pkg::NUM_W-1:0]      quo_r, quo_nxt;
  logic [icc_pkg::VALUE_W-1:0]    rem_r, rem_nxt;
  logic [icc_pkg::VALUE_W-1:0]    den_r, den_nxt;
  logic [icc_pkg::VALUE_W:0]      shifted;
  logic [icc_pkg::VALUE_W:0]      trial;
  logic                           fits;

  always_comb begin
    shifted  = {rem_r, quo_r[icc_pkg::NUM_W-1]};
    trial    = shifted - {1'b0, den_r};
    fits     = (shifted >= {1'b0, den_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = icc_pkg::DIV_CW'(icc_pkg::NUM_W - 1);
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      quo_nxt = {quo_r[icc_pkg::NUM_W-2:0], fits};
      rem_nxt = fits ? trial[icc_pkg::VALUE_W-1:0] : shifted[icc_pkg::VALUE_W-1:0];
      cnt_nxt = cnt_r - icc_pkg::DIV_CW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign res.done   = done_r;
  assign res.quo    = quo_r;
  assign res.rem_nz = (rem_r != '0);

endmodule

// ----- sim/iteration_count_colormap_top_test.sv -----
// ----------------------------------------------------------------------------
// iteration_count_colormap_top_test: self-checking bench for the colormap
// Fills the palette, then runs directed grayscale and palette cases and a set
// of random register settings. Each map item is predicted in the bench and
// each colour leaving the block is checked against the oldest prediction,
// with random gaps on both channels, a long output stall and a sender pause.
// ----------------------------------------------------------------------------
module iteration_count_colormap_top_test;

  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;

  // Mode code with no meaning of its own; the block treats it as grayscale.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [icc_pkg::COLOR_W-1:0] red;
    logic [icc_pkg::COLOR_W-1:0] green;
    logic [icc_pkg::COLOR_W-1:0] blue;
  } colour_t;

  logic                          clk;
  logic                          rst_n          = 1'b0;
  logic                          in_valid       = 1'b0;
  logic                          in_ready;
  logic                          in_action      = icc_pkg::ACT_LOAD;
  logic [icc_pkg::VALUE_W-1:0]   in_value       = '0;
  logic [icc_pkg::ENTRY_W-1:0]   in_entry_index = '0;
  logic [icc_pkg::COLOR_W-1:0]   in_entry_red   = '0;
  logic [icc_pkg::COLOR_W-1:0]   in_entry_green = '0;
  logic [icc_pkg::COLOR_W-1:0]   in_entry_blue  = '0;
  logic                          out_valid;
  logic                          out_ready      = 1'b0;
  logic [icc_pkg::COLOR_W-1:0]   out_red;
  logic [icc_pkg::COLOR_W-1:0]   out_green;
  logic [icc_pkg::COLOR_W-1:0]   out_blue;
  logic                          psel           = 1'b0;
  logic                          penable        = 1'b0;
  logic                          pwrite         = 1'b0;
  logic [icc_pkg::PADDR_W-1:0]   paddr          = '0;
  logic [icc_pkg::PDATA_W-1:0]   pwdata         = '0;
  logic [icc_pkg::PDATA_W-1:0]   prdata;
  logic                          pready;

  logic [1:0]                    cur_mode;
  logic [icc_pkg::VALUE_W-1:0]   cur_max;
  logic [icc_pkg::VALUE_W-1:0]   cur_min;
  logic [icc_pkg::SIZE_W-1:0]    cur_size;
  colour_t                       palette_copy [icc_pkg::PAL_DEPTH];
  colour_t                       pending_colours [$];

  int                            error_count  = 0;
  bit                            send_burst   = 1'b0;
  bit                            recv_burst   = 1'b0;
  bit                            hold_request = 1'b0;

  iteration_count_colormap_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_value       (in_value),
    .in_entry_index (in_entry_index),
    .in_entry_red   (in_entry_red),
    .in_entry_green (in_entry_green),
    .in_entry_blue  (in_entry_blue),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("iteration_count_colormap_top: mismatch");
    $finish;
  end

  function automatic int unsigned ceil_to_index(longint n, longint d, int unsigned last);
    longint q;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    if (n <= 0) return 0;
    q = (n + d - 1) / d;
    return (q > longint'(last)) ? last : 32'(q);
  endfunction

  function automatic colour_t predict_colour(logic [icc_pkg::VALUE_W-1:0] v);
    int unsigned sz;
    int unsigned last;
    int unsigned idx;
    longint      n;
    longint      d;
    longint      g;
    if (cur_mode == icc_pkg::MODE_ABS || cur_mode == icc_pkg::MODE_REL) begin
      sz = cur_size;
      if (sz == 0) sz = 1;
      if (sz > icc_pkg::PAL_DEPTH) sz = icc_pkg::PAL_DEPTH;
      last = sz - 1;
      if (v == 0 || cur_min == cur_max) begin
        idx = last;
      end else if (cur_mode == icc_pkg::MODE_ABS) begin
        if (cur_max == 0) begin
          idx = last;
        end else begin
          n   = longint'(v) * longint'(last);
          d   = longint'(cur_max);
          idx = ceil_to_index(n, d, last);
        end
      end else begin
        n   = (longint'(v) - longint'(cur_min)) * longint'(last);
        d   = longint'(cur_max) - longint'(cur_min);
        idx = ceil_to_index(n, d, last);
      end
      return palette_copy[idx % icc_pkg::PAL_DEPTH];
    end
    if (v == 0 || v >= cur_max) begin
      g = 0;
    end else begin
      g = ((longint'(cur_max) - longint'(v)) * 255 + longint'(cur_max) - 1)
          / longint'(cur_max);
    end
    return {3{g[icc_pkg::COLOR_W-1:0]}};
  endfunction

  function automatic logic [icc_pkg::VALUE_W-1:0] pick_value();
    int t;
    case ($urandom_range(0, 5))
      0: t = int'($urandom_range(0, 65535));
      1: t = 0;
      2: t = int'(cur_max) + int'($urandom_range(0, 6)) - 3;
      3: t = int'(cur_min) + int'($urandom_range(0, 6)) - 3;
      4: t = int'($urandom_range(0, 15));
      default: t = 65535 - int'($urandom_range(0, 15));
    endcase
    if (t < 0) t = 0;
    if (t > 65535) t = 65535;
    return icc_pkg::VALUE_W'(t);
  endfunction

  task automatic send_item(input logic act, input logic [icc_pkg::VALUE_W-1:0] v,
                           input logic [icc_pkg::ENTRY_W-1:0] idx, input colour_t rgb);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_value       <= v;
    in_entry_index <= idx;
    in_entry_red   <= rgb.red;
    in_entry_green <= rgb.green;
    in_entry_blue  <= rgb.blue;
    do @(posedge clk); while (!in_ready);
    if (act == icc_pkg::ACT_MAP) pending_colours.push_back(predict_colour(v));
    else palette_copy[idx] = rgb;
  endtask

  task automatic send_map(input logic [icc_pkg::VALUE_W-1:0] v);
    send_item(icc_pkg::ACT_MAP, v, icc_pkg::ENTRY_W'($urandom), colour_t'($urandom));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_colours.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] which,
                           input logic [icc_pkg::PDATA_W-1:0] data,
                           input logic [icc_pkg::PDATA_W-1:0] keep);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= ($urandom & ~keep) | (data & keep);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [1:0] m, input logic [icc_pkg::VALUE_W-1:0] mx,
                            input logic [icc_pkg::VALUE_W-1:0] mn,
                            input logic [icc_pkg::SIZE_W-1:0] sz);
    wait_idle();
    cfg_write(icc_pkg::REG_MODE, icc_pkg::PDATA_W'(m), 32'h3);
    cfg_write(icc_pkg::REG_MAX, icc_pkg::PDATA_W'(mx), 32'hFFFF);
    cfg_write(icc_pkg::REG_MIN, icc_pkg::PDATA_W'(mn), 32'hFFFF);
    cfg_write(icc_pkg::REG_SIZE, icc_pkg::PDATA_W'(sz), 32'h1FF);
    cur_mode = m;
    cur_max  = mx;
    cur_min  = mn;
    cur_size = sz;
  endtask

  // Every entry is written here, so no later map item can read an unwritten one.
  task automatic test_palette_load();
    for (int i = 0; i < icc_pkg::PAL_DEPTH; i++) begin
      if (i == 0)
        send_item(icc_pkg::ACT_LOAD, icc_pkg::VALUE_W'($urandom),
                  icc_pkg::ENTRY_W'(i), '0);
      else if (i == icc_pkg::PAL_DEPTH - 1)
        send_item(icc_pkg::ACT_LOAD, icc_pkg::VALUE_W'($urandom),
                  icc_pkg::ENTRY_W'(i), '1);
      else
        send_item(icc_pkg::ACT_LOAD, icc_pkg::VALUE_W'($urandom),
                  icc_pkg::ENTRY_W'(i), colour_t'($urandom));
    end
  endtask

  task automatic test_grayscale();
    send_map(0);
    send_map(1);
    send_map(254);
    send_map(255);
    send_map(16'hFFFF);
    set_config(icc_pkg::MODE_GRAY, 16'hFFFF, 0, 1);
    send_map(1);
    send_map(16'hFFFE);
    send_map(16'h7FFF);
    set_config(MODE_SPARE, 0, 0, 1);
    send_map(1);
  endtask

  task automatic test_palette_modes();
    set_config(icc_pkg::MODE_ABS, 16'hFFFF, 0, 256);
    send_map(0);
    send_map(1);
    send_map(16'h8000);
    send_map(16'hFFFF);
    set_config(icc_pkg::MODE_ABS, 100, 3, 0);
    send_map(50);
    set_config(icc_pkg::MODE_ABS, 100, 7, 511);
    send_map(300);
    send_map(100);
    set_config(icc_pkg::MODE_ABS, 0, 5, 16);
    send_map(3);
    set_config(icc_pkg::MODE_REL, 200, 100, 256);
    send_map(50);
    send_map(100);
    send_map(150);
    send_map(200);
    send_map(16'hFFFF);
    set_config(icc_pkg::MODE_REL, 100, 200, 64);
    send_map(50);
    send_map(150);
    send_map(250);
    set_config(icc_pkg::MODE_REL, 300, 300, 256);
    send_map(7);
  endtask

  task automatic test_random_settings();
    logic [1:0]                  m;
    logic [icc_pkg::VALUE_W-1:0] mx;
    logic [icc_pkg::VALUE_W-1:0] mn;
    logic [icc_pkg::SIZE_W-1:0]  sz;
    for (int phase = 0; phase < 11; phase++) begin
      case ($urandom_range(0, 9))
        0, 1: m = icc_pkg::MODE_GRAY;
        2: m = MODE_SPARE;
        3, 4, 5, 6: m = icc_pkg::MODE_ABS;
        default: m = icc_pkg::MODE_REL;
      endcase
      case ($urandom_range(0, 3))
        0: mx = icc_pkg::VALUE_W'($urandom);
        1: mx = icc_pkg::VALUE_W'($urandom_range(1, 300));
        2: mx = 16'hFFFF;
        default: mx = icc_pkg::VALUE_W'($urandom_range(0, 3));
      endcase
      case ($urandom_range(0, 3))
        0: mn = '0;
        1: mn = (mx > 20) ? mx - icc_pkg::VALUE_W'($urandom_range(1, 20)) : '0;
        2: mn = icc_pkg::VALUE_W'($urandom);
        default: mn = mx;
      endcase
      case ($urandom_range(0, 5))
        0: sz = icc_pkg::SIZE_W'(1);
        1: sz = icc_pkg::SIZE_W'(256);
        2, 3: sz = icc_pkg::SIZE_W'($urandom_range(1, 256));
        4: sz = icc_pkg::SIZE_W'($urandom_range(2, 16));
        default: sz = ($urandom_range(0, 1) == 0) ? '0 :
                      icc_pkg::SIZE_W'($urandom_range(257, 511));
      endcase
      case (phase)
        0: set_config(icc_pkg::MODE_ABS, 16'hFFFF, 0, 256);
        1: set_config(icc_pkg::MODE_REL, 16'hFFFF, 0, 256);
        2: set_config(icc_pkg::MODE_GRAY, 16'hFFFF, 0, 1);
        default: set_config(m, mx, mn, sz);
      endcase
      send_burst = (phase % 4 == 1);
      recv_burst = (phase % 4 == 2);
      repeat (105) begin
        if ($urandom_range(0, 4) == 0)
          send_item(icc_pkg::ACT_LOAD, icc_pkg::VALUE_W'($urandom),
                    icc_pkg::ENTRY_W'($urandom), colour_t'($urandom));
        else
          send_map(pick_value());
      end
    end
    send_burst = 1'b0;
    recv_burst = 1'b0;
  endtask

  task automatic test_output_stall();
    set_config(icc_pkg::MODE_ABS, icc_pkg::VALUE_W'($urandom_range(1, 65535)), 0, 256);
    hold_request = 1'b1;
    send_burst   = 1'b1;
    repeat (40) send_map(pick_value());
    send_burst   = 1'b0;
  endtask

  task automatic test_sender_pause();
    repeat (10) send_map(pick_value());
    wait_idle();
    repeat (10) send_map(pick_value());
  endtask

  initial begin
    int w;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      w = recv_burst ? 0 : $urandom_range(0, 11);
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : check_colour
    colour_t seen;
    colour_t want;
    if (rst_n && out_valid && out_ready) begin
      seen = {out_red, out_green, out_blue};
      if (pending_colours.size() == 0) begin
        error_count++;
        $display("%0t: colour %h/%h/%h arrived with none outstanding",
                 $time, seen.red, seen.green, seen.blue);
      end else begin
        want = pending_colours.pop_front();
        if (want !== seen) begin
          error_count++;
          $display("%0t: colour expected %h/%h/%h, got %h/%h/%h", $time,
                   want.red, want.green, want.blue, seen.red, seen.green, seen.blue);
        end
      end
    end
  end

  initial begin
    cur_mode = icc_pkg::MODE_GRAY;
    cur_max  = 255;
    cur_min  = 0;
    cur_size = 1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_palette_load();
    test_grayscale();
    test_palette_modes();
    test_random_settings();
    test_output_stall();
    test_sender_pause();
    wait_idle();
    if (error_count == 0) begin
      $display("iteration_count_colormap_top: match");
    end else begin
      $display("iteration_count_colormap_top: mismatch");
    end
    $finish;
  end

endmodule
